[sv/ausma_pkg.sv]
`timescale 1ns / 1ps

package ausma_pkg;

  // Window and axis geometry
  localparam int WINDOW_LENGTH = 12;
  localparam int SLOT_W        = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int NUM_AXES      = 3;

  // Data widths
  localparam int SAMPLE_W  = 14;
  localparam int SCALED_W  = 20;
  localparam int SUM_W     = SCALED_W + $clog2(WINDOW_LENGTH);
  localparam int ROW_W     = NUM_AXES * SCALED_W;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 64;

  // Divider geometry: dividend is |sample| * 9807 * 1024, divisor is 1000 * lsb_divisor
  localparam int DIV_W     = 37;
  localparam int DEN_W     = 23;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Mean by reciprocal: |sum| * ceil(2^MEAN_SHIFT / WINDOW_LENGTH) >> MEAN_SHIFT,
  // exact for every sum magnitude below 2^SUM_W
  localparam int MEAN_SHIFT  = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int MEAN_PROD_W = MEAN_SHIFT + SCALED_W;
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((64'd1 << MEAN_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  // Scale constants
  localparam logic [23:0] SCALE_NUM = 24'd10042368;
  localparam logic [9:0]  SCALE_DEN = 10'd1000;

  // Saturation bounds of the scaled sample
  localparam logic [DIV_W-1:0]    NEG_LIMIT = DIV_W'(524288);
  localparam logic [DIV_W-1:0]    POS_LIMIT = DIV_W'(524287);
  localparam logic [SCALED_W-1:0] S20_MAX   = 20'h7FFFF;
  localparam logic [SCALED_W-1:0] S20_MIN   = 20'h80000;

  // Configuration register file
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int DIVISOR_W = 13;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 13'd2048;
  localparam logic [0:0] REG_LSB_DIVISOR = 1'b0;

  typedef logic signed [SCALED_W-1:0] scaled_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Form the 14-bit sample from the two data bytes
  function automatic logic signed [SAMPLE_W-1:0] unpack_sample(input logic [7:0] lo,
                                                                input logic [7:0] hi);
    logic [15:0] word;
    begin
      word = {hi, lo};
      return $signed(word[15:2]);
    end
  endfunction

  // Magnitude of a 14-bit sample; -8192 maps to 8192
  function automatic logic [SAMPLE_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] s);
    begin
      return s[SAMPLE_W-1] ? (~s + SAMPLE_W'(1)) : s;
    end
  endfunction

endpackage

[sv/ausma_ram.sv]
`timescale 1ns / 1ps

module ausma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/ausma_div.sv]
`timescale 1ns / 1ps

module ausma_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ausma_pkg::DIV_W-1:0]   dividend,
  input  logic [ausma_pkg::DEN_W-1:0]   divisor,
  output logic                          done,
  output logic [ausma_pkg::DIV_W-1:0]   quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [ausma_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ausma_pkg::DIV_W-1:0]       quo_r, quo_nxt;
  logic [ausma_pkg::DEN_W:0]         rem_r, rem_nxt;
  logic [ausma_pkg::DEN_W-1:0]       dvs_r, dvs_nxt;
  logic [ausma_pkg::DEN_W:0]         rem_sh;
  logic [ausma_pkg::DEN_W:0]         diff;
  logic                              ge;

  // One restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    rem_sh   = {rem_r[ausma_pkg::DEN_W-1:0], quo_r[ausma_pkg::DIV_W-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    ge       = (rem_sh >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[ausma_pkg::DIV_W-2:0], ge};
      rem_nxt = ge ? diff : rem_sh;
      cnt_nxt = cnt_r + ausma_pkg::DIV_CNT_W'(1);
      if (cnt_r == ausma_pkg::DIV_CNT_W'(ausma_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset, datapath free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[sv/accel_unpack_scale_moving_average.sv]
`timescale 1ns / 1ps

// Three-axis accelerometer unpack, scale and 12-sample moving average. Each input
// transaction carries the six axis data bytes and a read-ok flag; each produces one
// output transaction with the windowed means of x, y and z in 1/1024 m/s^2. The
// block works on one transaction at a time: the next transaction is taken only
// once its result is loaded into the output register and the state is back in
// idle. Three dividers, one per axis, each retire one quotient bit a cycle over
// 37 steps for the scaling by 9.807/lsb_divisor; the scaling pass is skipped on
// a failed read. The mean takes one registered step: the window sum magnitude is
// multiplied by a reciprocal of the window length and shifted, which truncates
// toward zero. The window rings live in one RAM row per slot; a valid bit per row
// makes rows never written since reset read as zero, so no clearing pass is
// needed. in_tready is high only while no transaction is in work; a finished
// result waits in the output register until taken, and the next result stalls
// behind it.
module accel_unpack_scale_moving_average (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] x_low_byte, [15:8] x_high_byte, [23:16] y_low_byte,
  // [31:24] y_high_byte, [39:32] z_low_byte, [47:40] z_high_byte
  input  logic [ausma_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] read_ok
  input  logic                                in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [19:0] avg_x, [39:20] avg_y, [59:40] avg_z, [63:60] zero
  output logic [ausma_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ausma_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [ausma_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [ausma_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                                cfg_pready
);

  localparam int NA = ausma_pkg::NUM_AXES;
  localparam int SW = ausma_pkg::SCALED_W;
  localparam int UW = ausma_pkg::SUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SGO, S_SWAIT, S_SFIN, S_UPD, S_MGO, S_OUT
  } state_t;

  state_t                                  state_r, state_nxt;
  logic [ausma_pkg::DIVISOR_W-1:0]         lsb_div_r, lsb_div_nxt;
  logic [ausma_pkg::SLOT_W-1:0]            slot_r, slot_nxt;
  logic [ausma_pkg::WINDOW_LENGTH-1:0]     row_valid_r, row_valid_nxt;
  logic                                    read_ok_r, read_ok_nxt;
  logic [ausma_pkg::IN_DATA_W-1:0]         bytes_r, bytes_nxt;
  logic [ausma_pkg::DEN_W-1:0]             den_r, den_nxt;
  logic                                    den_zero_r, den_zero_nxt;
  logic [ausma_pkg::DIV_W-1:0]             prod_r [NA];
  logic [ausma_pkg::DIV_W-1:0]             prod_nxt [NA];
  logic                                    neg_r [NA];
  logic                                    neg_nxt [NA];
  logic [SW-1:0]                           old_r [NA];
  logic [SW-1:0]                           old_nxt [NA];
  logic [SW-1:0]                           last_r [NA];
  logic [SW-1:0]                           last_nxt [NA];
  logic [UW-1:0]                           sums_r [NA];
  logic [UW-1:0]                           sums_nxt [NA];
  logic [SW-1:0]                           mq_r [NA];
  logic [SW-1:0]                           mq_nxt [NA];
  logic [ausma_pkg::OUT_DATA_W-1:0]        out_data_r, out_data_nxt;
  logic                                    out_valid_r, out_valid_nxt;

  logic                                    in_fire;
  logic                                    cfg_wr;
  logic                                    ram_we;
  logic [ausma_pkg::ROW_W-1:0]             ram_wdata;
  logic [ausma_pkg::ROW_W-1:0]             ram_rdata;
  logic                                    div_start;
  logic [NA-1:0]                           div_done;
  logic [ausma_pkg::DIV_W-1:0]             div_quo [NA];
  logic [UW-1:0]                           sum_mag [NA];
  logic [SW-1:0]                           mean [NA];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == ausma_pkg::REG_LSB_DIVISOR);
  assign cfg_prdata = (cfg_paddr[2] == ausma_pkg::REG_LSB_DIVISOR) ?
                      ausma_pkg::CFG_DW'(lsb_div_r) : '0;

  // Window ring storage, one row of three axes per slot
  ausma_ram #(
    .WIDTH (ausma_pkg::ROW_W),
    .DEPTH (ausma_pkg::WINDOW_LENGTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // Divider runs the scaling pass only
  assign div_start = (state_r == S_SGO);

  for (genvar a = 0; a < NA; a++) begin : g_axis
    assign sum_mag[a] = sums_r[a][UW-1] ? (~sums_r[a] + UW'(1)) : sums_r[a];
    assign mean[a] = sums_r[a][UW-1] ? (~mq_r[a] + SW'(1)) : mq_r[a];

    ausma_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (prod_r[a]),
      .divisor  (den_r),
      .done     (div_done[a]),
      .quotient (div_quo[a])
    );
  end

  assign ram_we    = (state_r == S_UPD);
  assign ram_wdata = {last_r[2], last_r[1], last_r[0]};

  // Sequence one transaction: read row, scale a good read, update ring and sums, average
  always_comb begin
    logic signed [ausma_pkg::SAMPLE_W-1:0] smp;
    logic [ausma_pkg::SAMPLE_W-1:0]        mag;
    logic [ausma_pkg::DIV_W-1:0]           prod_full;
    logic [ausma_pkg::MEAN_PROD_W-1:0]     mean_prod;
    smp           = '0;
    mag           = '0;
    prod_full     = '0;
    mean_prod     = '0;
    state_nxt     = state_r;
    lsb_div_nxt   = lsb_div_r;
    slot_nxt      = slot_r;
    row_valid_nxt = row_valid_r;
    read_ok_nxt   = read_ok_r;
    bytes_nxt     = bytes_r;
    den_nxt       = den_r;
    den_zero_nxt  = den_zero_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    for (int a = 0; a < NA; a++) begin
      prod_nxt[a] = prod_r[a];
      neg_nxt[a]  = neg_r[a];
      old_nxt[a]  = old_r[a];
      last_nxt[a] = last_r[a];
      sums_nxt[a] = sums_r[a];
      mq_nxt[a]   = mq_r[a];
    end

    if (cfg_wr) begin
      lsb_div_nxt = cfg_pwdata[ausma_pkg::DIVISOR_W-1:0];
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          read_ok_nxt = in_tuser;
          bytes_nxt   = in_tdata;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        // Register products and the old ring row
        den_nxt      = ausma_pkg::DEN_W'(lsb_div_r) * ausma_pkg::DEN_W'(ausma_pkg::SCALE_DEN);
        den_zero_nxt = (lsb_div_r == '0);
        for (int a = 0; a < NA; a++) begin
          smp         = ausma_pkg::unpack_sample(bytes_r[16*a +: 8], bytes_r[16*a+8 +: 8]);
          mag         = ausma_pkg::sample_mag(smp);
          prod_full   = mag * ausma_pkg::SCALE_NUM;
          prod_nxt[a] = prod_full;
          neg_nxt[a]  = smp[ausma_pkg::SAMPLE_W-1];
          old_nxt[a]  = row_valid_r[slot_r] ? ram_rdata[SW*a +: SW] : '0;
        end
        state_nxt = read_ok_r ? S_SGO : S_UPD;
      end
      S_SGO: begin
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (div_done[0]) begin
          state_nxt = S_SFIN;
        end
      end
      S_SFIN: begin
        // Apply sign, saturation and the zero-divisor case
        for (int a = 0; a < NA; a++) begin
          if (den_zero_r) begin
            last_nxt[a] = '0;
          end else if (neg_r[a]) begin
            last_nxt[a] = (div_quo[a] > ausma_pkg::NEG_LIMIT) ? ausma_pkg::S20_MIN :
                          (~div_quo[a][SW-1:0] + SW'(1));
          end else begin
            last_nxt[a] = (div_quo[a] > ausma_pkg::POS_LIMIT) ? ausma_pkg::S20_MAX :
                          div_quo[a][SW-1:0];
          end
        end
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // Swap the new sample into the ring and the running sum
        for (int a = 0; a < NA; a++) begin
          sums_nxt[a] = sums_r[a] + {{(UW-SW){last_r[a][SW-1]}}, last_r[a]}
                                  - {{(UW-SW){old_r[a][SW-1]}}, old_r[a]};
        end
        row_valid_nxt[slot_r] = 1'b1;
        state_nxt = S_MGO;
      end
      S_MGO: begin
        // Divide the sum magnitude by the window length through its reciprocal
        for (int a = 0; a < NA; a++) begin
          mean_prod = sum_mag[a] * ausma_pkg::MEAN_RECIP;
          mq_nxt[a] = mean_prod[ausma_pkg::MEAN_SHIFT +: SW];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Load the result once the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {{(ausma_pkg::OUT_DATA_W - ausma_pkg::ROW_W){1'b0}},
                           mean[2], mean[1], mean[0]};
          out_valid_nxt = 1'b1;
          slot_nxt = (slot_r == ausma_pkg::SLOT_W'(ausma_pkg::WINDOW_LENGTH - 1)) ?
                     '0 : slot_r + ausma_pkg::SLOT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lsb_div_r   <= ausma_pkg::DIVISOR_RESET;
      slot_r      <= '0;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        last_r[a] <= '0;
        sums_r[a] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      lsb_div_r   <= lsb_div_nxt;
      slot_r      <= slot_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
      for (int a = 0; a < NA; a++) begin
        last_r[a] <= last_nxt[a];
        sums_r[a] <= sums_nxt[a];
      end
    end
    read_ok_r  <= read_ok_nxt;
    bytes_r    <= bytes_nxt;
    den_r      <= den_nxt;
    den_zero_r <= den_zero_nxt;
    out_data_r <= out_data_nxt;
    for (int a = 0; a < NA; a++) begin
      prod_r[a] <= prod_nxt[a];
      neg_r[a]  <= neg_nxt[a];
      old_r[a]  <= old_nxt[a];
      mq_r[a]   <= mq_nxt[a];
    end
  end

  // A result is loaded only from the output step
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside the output step");

  // The three axis dividers run in lock step
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> (div_done[1] && div_done[2]))
    else $error("axis dividers out of step");

  // A divider finishes only while the sequencer waits for it
  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> (state_r == S_SWAIT))
    else $error("divider finished outside the wait step");

  // Ring slot stays inside the window
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < ausma_pkg::SLOT_W'(ausma_pkg::WINDOW_LENGTH))
    else $error("ring slot out of range");

  // An accepted transaction moves straight to the row read step
  a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MUL))
    else $error("accepted transaction not started");

endmodule

[verif/accel_average_checker.sv]
`timescale 1ns / 1ps

module accel_average_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // [7:0] x_low_byte, [15:8] x_high_byte, [23:16] y_low_byte,
  // [31:24] y_high_byte, [39:32] z_low_byte, [47:40] z_high_byte
  input  logic [ausma_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] read_ok
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // [19:0] avg_x, [39:20] avg_y, [59:40] avg_z, [63:60] zero
  input  logic [ausma_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ausma_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [ausma_pkg::CFG_DW-1:0]     cfg_pwdata,
  input  logic [ausma_pkg::CFG_DW-1:0]     cfg_prdata,
  input  logic                             cfg_pready,
  output int                               mismatch_count,
  output int                               outstanding,
  output int                               results_checked
);
  import ausma_pkg::*;

  localparam logic [CFG_AW-1:0]    DIVISOR_ADDR     = CFG_AW'(4 * REG_LSB_DIVISOR);
  localparam logic [DIVISOR_W-1:0] DIVISOR_AT_RESET = 13'd2048;
  // 9.807 m/s^2 per g with 10 fractional bits, kept as 9807 * 1024 over 1000
  localparam longint unsigned      GAIN_NUM         = 64'd10042368;
  localparam longint unsigned      GAIN_DEN         = 64'd1000;
  localparam logic [SCALED_W-1:0]  ACCEL_MAX        = 20'h7FFFF;
  localparam logic [SCALED_W-1:0]  ACCEL_MIN        = 20'h80000;

  typedef struct packed {
    logic [3:0]          pad;
    logic [SCALED_W-1:0] avg_z;
    logic [SCALED_W-1:0] avg_y;
    logic [SCALED_W-1:0] avg_x;
  } mean_row_t;

  // Shadow state of the filter
  logic [DIVISOR_W-1:0]       divisor;
  logic signed [SCALED_W-1:0] ring [NUM_AXES][WINDOW_LENGTH];
  logic signed [SCALED_W-1:0] held_accel [NUM_AXES];
  longint                     ring_sum [NUM_AXES];
  int                         slot;
  mean_row_t                  expected_means [$];

  // Drop the two low bits of the 16-bit word, keep the sign
  function automatic int unpack_axis(input logic [15:0] word);
    logic signed [SAMPLE_W-1:0] s;
    s = word[15:2];
    return int'(s);
  endfunction

  // Scale to 1/1024 m/s^2, truncate toward zero, saturate to 20 bits
  function automatic logic signed [SCALED_W-1:0] scale_to_accel(
      input int sample, input logic [DIVISOR_W-1:0] div);
    longint unsigned mag;
    longint unsigned den;
    longint unsigned quo;
    mag = (sample < 0) ? longint'(-sample) : longint'(sample);
    den = GAIN_DEN * div;
    if (den == 0) return '0;
    quo = (mag * GAIN_NUM) / den;
    if (sample < 0) return (quo > 64'd524288) ? ACCEL_MIN : SCALED_W'(-longint'(quo));
    return (quo > 64'd524287) ? ACCEL_MAX : SCALED_W'(quo);
  endfunction

  task automatic reset_filter();
    divisor = DIVISOR_AT_RESET;
    slot = 0;
    for (int a = 0; a < NUM_AXES; a++) begin
      held_accel[a] = '0;
      ring_sum[a] = 0;
      for (int i = 0; i < WINDOW_LENGTH; i++) ring[a][i] = '0;
    end
    expected_means.delete();
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic compare_field(input string what, input logic [SCALED_W-1:0] want,
                               input logic [SCALED_W-1:0] got);
    if (got !== want) report_mismatch(what, $signed(want), $signed(got));
  endtask

  // Push one reading through the window and queue the resulting means
  task automatic absorb_reading(input logic ok, input logic [IN_DATA_W-1:0] bytes);
    mean_row_t row;
    longint    avg [NUM_AXES];
    if (ok) begin
      for (int a = 0; a < NUM_AXES; a++)
        held_accel[a] = scale_to_accel(unpack_axis(bytes[16*a +: 16]), divisor);
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      ring_sum[a] += longint'(held_accel[a]) - longint'(ring[a][slot]);
      ring[a][slot] = held_accel[a];
      avg[a] = ring_sum[a] / WINDOW_LENGTH;
    end
    row.pad   = '0;
    row.avg_x = SCALED_W'(avg[0]);
    row.avg_y = SCALED_W'(avg[1]);
    row.avg_z = SCALED_W'(avg[2]);
    expected_means.push_back(row);
    slot = (slot + 1) % WINDOW_LENGTH;
  endtask

  task automatic check_means(input logic [OUT_DATA_W-1:0] data);
    mean_row_t got;
    mean_row_t want;
    got = data;
    results_checked++;
    if (expected_means.size() == 0) begin
      report_mismatch("result with none due, avg_x", 0, $signed(got.avg_x));
      return;
    end
    want = expected_means.pop_front();
    compare_field("avg_x", want.avg_x, got.avg_x);
    compare_field("avg_y", want.avg_y, got.avg_y);
    compare_field("avg_z", want.avg_z, got.avg_z);
    if (got.pad !== want.pad) report_mismatch("out_tdata padding", want.pad, got.pad);
  endtask

  // Track register access, then results, then new readings
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_filter();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == DIVISOR_ADDR) begin
        if (cfg_pwrite)
          divisor = cfg_pwdata[DIVISOR_W-1:0];
        else if (cfg_prdata !== CFG_DW'(divisor))
          report_mismatch("lsb_divisor readback", CFG_DW'(divisor), cfg_prdata);
      end
      if (out_tvalid && out_tready) check_means(out_tdata);
      if (in_tvalid && in_tready) absorb_reading(in_tuser, in_tdata);
    end
    outstanding = expected_means.size();
  end

endmodule

[verif/accel_unpack_scale_moving_average_test.sv]
`timescale 1ns / 1ps

module accel_unpack_scale_moving_average_test;
  import ausma_pkg::*;

  localparam logic [CFG_AW-1:0] DIVISOR_ADDR       = CFG_AW'(4 * REG_LSB_DIVISOR);
  localparam logic [CFG_AW-1:0] SPARE_ADDR         = CFG_AW'(4);
  localparam int                RANDOM_PHASES      = 8;
  localparam int                READINGS_PER_PHASE = 230;
  localparam int                HOLD_AFTER         = 600;
  localparam int                HOLD_CYCLES        = 300;
  localparam int                DRAIN_CYCLES       = 200;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // x, y, z words, each {high_byte, low_byte}
  logic                  in_tuser;   // [0] read_ok
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [19:0] avg_x, [39:20] avg_y, [59:40] avg_z
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [CFG_DW-1:0]     cfg_pwdata;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  int mismatch_count;
  int outstanding;
  int results_checked;
  int items_sent     = 0;
  int settings_used  = 0;
  bit burst_mode     = 1'b0;
  bit hold_armed     = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  accel_unpack_scale_moving_average dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  accel_average_checker avg_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Mostly short idle gaps, a few long ones, none in burst phases
  function automatic int pick_gap();
    int roll;
    if (burst_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Mostly random words, some at the sample extremes and around the dropped bits
  function automatic logic [15:0] random_axis_word();
    if ($urandom_range(0, 4) != 0) return 16'($urandom());
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h7FFC;
      3:       return 16'h8003;
      4:       return 16'h0000;
      5:       return 16'hFFFF;
      6:       return 16'h0003;
      default: return 16'hFFFC;
    endcase
  endfunction

  task automatic apb_access(input logic is_write, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Offer one reading, hold it until taken
  task automatic send_reading(input logic ok, input logic [IN_DATA_W-1:0] bytes);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tdata  <= bytes;
    in_tuser  <= ok;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop offering and wait until every result has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Change the divisor with the block idle; upper data bits are don't-care
  task automatic set_divisor(input logic [DIVISOR_W-1:0] value);
    logic [CFG_DW-1:0] data;
    data = $urandom();
    data[DIVISOR_W-1:0] = value;
    wait_drained();
    apb_access(1'b1, DIVISOR_ADDR, data);
    apb_access(1'b0, DIVISOR_ADDR, '0);
    settings_used++;
  endtask

  initial begin : stimulus
    logic [DIVISOR_W-1:0] div;
    logic [IN_DATA_W-1:0] bytes;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the divisor, then readings while the window is still filling
    apb_access(1'b0, DIVISOR_ADDR, '0);
    send_reading(1'b0, 48'hA5A5_5A5A_C3C3);
    send_reading(1'b1, 48'h0);
    send_reading(1'b1, {16'hFFFF, 16'h8000, 16'h7FFF});
    send_reading(1'b0, 48'hFFFF_FFFF_FFFF);
    send_reading(1'b1, {16'h0004, 16'hFFFC, 16'h0003});
    send_reading(1'b1, {16'h8003, 16'h7FFC, 16'h8000});

    // Zero divisor scales everything to zero
    set_divisor(13'd0);
    send_reading(1'b1, {16'h7FFF, 16'h8000, 16'h1234});
    send_reading(1'b0, 48'h1357_9BDF_2468);

    // Divisor 1 saturates the scaled sample, divisor 255 stays inside its range
    set_divisor(13'd1);
    send_reading(1'b1, {16'h8000, 16'h7FFF, 16'h0008});
    send_reading(1'b1, {16'h0004, 16'hFFF8, 16'h7FFC});
    set_divisor(13'd255);
    send_reading(1'b1, {16'h7FFF, 16'h8000, 16'h4000});

    // Largest divisor, then a failed read that keeps the old scaled values
    set_divisor(13'h1FFF);
    send_reading(1'b1, {16'h8000, 16'h7FFF, 16'h0100});
    send_reading(1'b0, 48'h0F0F_F0F0_3C3C);

    // Writes to an unmapped address leave the divisor alone
    wait_drained();
    apb_access(1'b1, SPARE_ADDR, 32'd5);
    apb_access(1'b0, DIVISOR_ADDR, '0);
    send_reading(1'b1, {16'h2000, 16'hE000, 16'h1000});

    set_divisor(13'd256);
    send_reading(1'b1, {16'h7FFC, 16'h8000, 16'hFFFC});
    set_divisor(13'd4096);
    send_reading(1'b1, {16'h8000, 16'h7FFC, 16'h0004});

    // Random phases, each under its own divisor
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:                 div = 13'd256;
        1:                 div = 13'd4096;
        RANDOM_PHASES - 1: div = DIVISOR_W'($urandom_range(0, 8191));
        default:           div = DIVISOR_W'($urandom_range(256, 4096));
      endcase
      set_divisor(div);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < READINGS_PER_PHASE; i++) begin
        bytes = {random_axis_word(), random_axis_word(), random_axis_word()};
        send_reading($urandom_range(0, 99) < 85, bytes);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d averaged results from %0d readings under %0d divisor settings,",
             results_checked, items_sent, settings_used);
    $display("with failed reads, zero and saturating divisors and a long output stall.");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Take results with random stalls; once, hold off long enough to back up the input
  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    forever begin
      if (hold_armed && items_sent >= HOLD_AFTER) begin
        hold_armed = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("Timeout with %0d results still due", outstanding);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[accel_unpack_scale_moving_average.f]
sv/ausma_pkg.sv
sv/ausma_ram.sv
sv/ausma_div.sv
sv/accel_unpack_scale_moving_average.sv
verif/accel_average_checker.sv
verif/accel_unpack_scale_moving_average_test.sv
